FILE: rtl/bfei_pkg.sv
// shared types, constants and helper functions of the bit-field extract/insert block
`timescale 1ns / 1ps

package bfei_pkg;

  // buffer geometry
  localparam int BUF_BYTES      = 256;
  localparam int BUF_AW         = $clog2(BUF_BYTES);
  localparam int BUF_BITS       = BUF_BYTES * 8;
  localparam int MAX_FIELD_BITS = 64;

  // field and register widths
  localparam int IDX_W    = 11;
  localparam int LEN_W    = 7;
  localparam int VAL_W    = 64;
  localparam int NB_W     = 4;
  localparam int CFG_DW   = 11;
  localparam int CFG_IW   = 1;
  localparam int WIN_W    = VAL_W + 8;
  localparam int CNT_W    = 4;
  localparam int SRC_MAX  = 8;

  // operation codes
  typedef enum logic [1:0] {
    OP_WR_BYTE = 2'd0,
    OP_RD_BYTE = 2'd1,
    OP_EXTRACT = 2'd2,
    OP_INSERT  = 2'd3
  } op_e;

  // configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    REG_FIELD_INDEX  = 1'b0,
    REG_FIELD_LENGTH = 1'b1
  } cfg_reg_e;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_STEP,
    ST_FINISH
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic clr;
    logic accept;
    logic wr_byte;
    logic rd;
    logic step;
    logic finish;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    op_e  op;
    logic skip;
    logic last;
    logic clr_last;
  } status_t;

  // low n bits set, n up to 64
  function automatic logic [VAL_W-1:0] field_mask(input logic [LEN_W-1:0] n);
    logic [VAL_W-1:0] m;
    if (n == '0) begin
      m = '0;
    end else begin
      m = {VAL_W{1'b1}} >> (7'(VAL_W) - n);
    end
    return m;
  endfunction

  // low 8*nb bits set, nb up to 8
  function automatic logic [VAL_W-1:0] src_mask(input logic [NB_W-1:0] nb);
    logic [VAL_W-1:0] m;
    if (nb == '0) begin
      m = '0;
    end else begin
      m = {VAL_W{1'b1}} >> (7'(VAL_W) - {nb, 3'b000});
    end
    return m;
  endfunction

endpackage

FILE: rtl/bfei_ctrl.sv
// controller state machine: clearing pass, item sequencing and output handshake
`timescale 1ns / 1ps

module bfei_ctrl
  import bfei_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // state and output-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (status_i.op == OP_WR_BYTE) begin
          cmd_o.wr_byte = 1'b1;
          state_d       = ST_FINISH;
        end else if (status_i.skip) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd_o.step = 1'b1;
        if (status_i.last) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.rd = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/bfei_datapath.sv
// datapath: config registers, item registers, backing buffer, byte merge and result registers
`timescale 1ns / 1ps

module bfei_datapath
  import bfei_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_IW-1:0]   cfg_index_i,
  input  logic [CFG_DW-1:0]   cfg_data_i,
  input  logic [1:0]          op_i,
  input  logic [7:0]          byte_addr_i,
  input  logic [7:0]          byte_data_i,
  input  logic [VAL_W-1:0]    insert_value_i,
  input  logic [NB_W-1:0]     source_bytes_i,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  output logic [VAL_W-1:0]    field_value_o,
  output logic [7:0]          byte_out_o,
  output logic                range_error_o
);

  // configuration
  logic [IDX_W-1:0] cfg_idx_q;
  logic [LEN_W-1:0] cfg_len_q;

  // item state
  op_e              op_q;
  logic [BUF_AW-1:0] base_q;
  logic [7:0]       data_q;
  logic [2:0]       off_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] k_q;
  logic             err_q;
  logic             skip_q;
  logic [WIN_W-1:0] fmask_q;
  logic [WIN_W-1:0] ins_q;
  logic [WIN_W-1:0] window_q;

  // buffer
  logic [7:0]        mem_q [BUF_BYTES];
  logic [7:0]        rdata_q;
  logic [BUF_AW-1:0] clr_cnt_q;

  // result registers
  logic [VAL_W-1:0] field_value_q;
  logic [7:0]       byte_out_q;
  logic             range_error_q;

  // setup values worked out at accept
  logic [LEN_W-1:0]  n_sat;
  logic [IDX_W:0]    end_bit;
  logic              ferr;
  logic              berr;
  logic [NB_W-1:0]   nb_sat;
  logic [7:0]        span;
  logic [CNT_W-1:0]  fcnt;
  logic [VAL_W-1:0]  src_lim;
  logic [VAL_W-1:0]  fm;

  // buffer access
  logic [CNT_W-1:0]  k_sel;
  logic [BUF_AW-1:0] raddr;
  logic              we;
  logic [BUF_AW-1:0] waddr;
  logic [7:0]        wdata;
  logic [7:0]        lane_m;
  logic [7:0]        lane_s;
  logic [7:0]        merged;
  logic [6:0]        lane_pos;

  // field geometry from the config registers, plus the byte-address and source-byte limits
  always_comb begin
    n_sat   = (cfg_len_q > LEN_W'(MAX_FIELD_BITS)) ? LEN_W'(MAX_FIELD_BITS) : cfg_len_q;
    end_bit = (IDX_W+1)'(cfg_idx_q) + (IDX_W+1)'(n_sat);
    ferr    = end_bit > (IDX_W+1)'(BUF_BITS);
    berr    = {1'b0, byte_addr_i} >= (BUF_AW+1)'(BUF_BYTES);
    nb_sat  = (source_bytes_i > NB_W'(SRC_MAX)) ? NB_W'(SRC_MAX) : source_bytes_i;
    span    = 8'(cfg_idx_q[2:0]) + 8'(n_sat) + 8'd7;
    fcnt    = CNT_W'(span >> 3);
    src_lim = insert_value_i & src_mask(nb_sat);
    fm      = field_mask(n_sat);
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_idx_q <= '0;
      cfg_len_q <= LEN_W'(8);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FIELD_INDEX:  cfg_idx_q <= cfg_data_i[IDX_W-1:0];
        REG_FIELD_LENGTH: cfg_len_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture and byte walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q       <= '0;
      clr_cnt_q <= '0;
    end else begin
      if (cmd_i.clr) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.accept) begin
        k_q <= '0;
      end else if (cmd_i.step) begin
        k_q <= k_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q     <= op_e'(op_i);
      data_q   <= byte_data_i;
      window_q <= '0;
      off_q    <= cfg_idx_q[2:0];
      fmask_q  <= {8'b0, fm} << cfg_idx_q[2:0];
      ins_q    <= {8'b0, src_lim} << cfg_idx_q[2:0];
      if (op_i == OP_WR_BYTE || op_i == OP_RD_BYTE) begin
        base_q <= byte_addr_i;
        cnt_q  <= CNT_W'(1);
        err_q  <= berr;
        skip_q <= berr;
      end else begin
        base_q <= cfg_idx_q[IDX_W-1:3];
        cnt_q  <= fcnt;
        err_q  <= ferr;
        skip_q <= ferr || (n_sat == '0);
      end
    end else if (cmd_i.step) begin
      window_q[lane_pos +: 8] <= rdata_q;
    end
  end

  // read and write address selection
  always_comb begin
    k_sel    = cmd_i.step ? k_q + 1'b1 : k_q;
    raddr    = base_q + BUF_AW'(k_sel);
    lane_pos = {k_q[3:0], 3'b000};
    lane_m   = fmask_q[lane_pos +: 8];
    lane_s   = ins_q[lane_pos +: 8];
    merged   = (rdata_q & ~lane_m) | (lane_s & lane_m);
    we       = 1'b0;
    waddr    = base_q;
    wdata    = data_q;
    if (cmd_i.clr) begin
      we    = 1'b1;
      waddr = clr_cnt_q;
      wdata = '0;
    end else if (cmd_i.wr_byte) begin
      we    = !err_q;
    end else if (cmd_i.step && op_q == OP_INSERT) begin
      we    = 1'b1;
      waddr = base_q + BUF_AW'(k_q);
      wdata = merged;
    end
  end

  // backing buffer
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      field_value_q <= (op_q == OP_EXTRACT && !err_q) ?
                       VAL_W'((window_q & fmask_q) >> off_q) : '0;
      byte_out_q    <= (op_q == OP_RD_BYTE) ? window_q[7:0] : 8'h00;
      range_error_q <= err_q;
    end
  end

  // status back to the controller
  always_comb begin
    status_o.op       = op_q;
    status_o.skip     = skip_q;
    status_o.last     = (k_q == cnt_q - 1'b1);
    status_o.clr_last = (clr_cnt_q == BUF_AW'(BUF_BYTES - 1));
  end

  assign field_value_o = field_value_q;
  assign byte_out_o    = byte_out_q;
  assign range_error_o = range_error_q;

endmodule

FILE: rtl/buffer_bit_field_extract_insert_top.sv
// top level of the bit-field extract/insert block over a 256-byte buffer
`timescale 1ns / 1ps
//
// Input channel (in_valid_i / in_ready_o) carries one item: a byte write,
// a byte read, a field extract or a field insert. Each item gives exactly
// one result on the output channel (out_valid_o / out_ready_i).
// The field is set through the write port: register 0 is the bit index,
// register 1 the bit length; write them only while the block is idle.
// A byte write or a skipped field goes straight to its result; reads,
// extracts and inserts first walk the buffer bytes they touch, up to
// nine buffer bytes for a 64-bit field.
// Items are handled one at a time: in_ready_o rises together with
// out_valid_o as an item finishes. The walk reads one buffer byte (and
// for an insert, writes it back) per cycle.
// After reset a clearing pass writes zero to all 256 buffer bytes,
// during which no item is accepted; config writes still land.
// The result sits in an output register: a new item is accepted while it
// waits, and the block holds in its final step if the receiver stalls.
//

module buffer_bit_field_extract_insert_top
  import bfei_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_IW-1:0]  cfg_index_i,
  input  logic [CFG_DW-1:0]  cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic [7:0]         byte_addr_i,
  input  logic [7:0]         byte_data_i,
  input  logic [VAL_W-1:0]   insert_value_i,
  input  logic [NB_W-1:0]    source_bytes_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [VAL_W-1:0]   field_value_o,
  output logic [7:0]         byte_out_o,
  output logic               range_error_o
);

  cmd_t    cmd;
  status_t status;

  // sequencing
  bfei_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // buffer and field logic
  bfei_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .op_i           (op_i),
    .byte_addr_i    (byte_addr_i),
    .byte_data_i    (byte_data_i),
    .insert_value_i (insert_value_i),
    .source_bytes_i (source_bytes_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .field_value_o  (field_value_o),
    .byte_out_o     (byte_out_o),
    .range_error_o  (range_error_o)
  );

endmodule

FILE: tb/tb_buffer_bit_field_extract_insert_top.sv
// testbench of the bit-field extract/insert block: directed and random items checked against a predictor
`timescale 1ns / 1ps

module tb_buffer_bit_field_extract_insert_top;
  import bfei_pkg::*;

  localparam int STALL_PCT       = 21;
  localparam int WATCHDOG_CYCLES = 3000;
  localparam int RANDOM_PHASES   = 12;
  localparam int PHASE_ITEMS     = 127;
  localparam int PRINT_LIMIT     = 40;

  // one result item as the block should return it
  typedef struct {
    logic [VAL_W-1:0] field_value;
    logic [7:0]       byte_out;
    logic             range_error;
  } outcome_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              cfg_we_i       = 1'b0;
  logic [CFG_IW-1:0] cfg_index_i    = '0;
  logic [CFG_DW-1:0] cfg_data_i     = '0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic [1:0]        op_i           = '0;
  logic [7:0]        byte_addr_i    = '0;
  logic [7:0]        byte_data_i    = '0;
  logic [VAL_W-1:0]  insert_value_i = '0;
  logic [NB_W-1:0]   source_bytes_i = '0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic [VAL_W-1:0]  field_value_o;
  logic [7:0]        byte_out_o;
  logic              range_error_o;

  // buffer contents and field registers as the block should hold them
  logic [7:0]       buf_image [BUF_BYTES] = '{default: '0};
  logic [IDX_W-1:0] field_index  = '0;
  logic [LEN_W-1:0] field_length = LEN_W'(8);

  outcome_t outcomes_due[$];
  int       mismatches   = 0;
  int       quiet_cycles = 0;
  bit       no_idling    = 1'b0;

  buffer_bit_field_extract_insert_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .byte_addr_i    (byte_addr_i),
    .byte_data_i    (byte_data_i),
    .insert_value_i (insert_value_i),
    .source_bytes_i (source_bytes_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .field_value_o  (field_value_o),
    .byte_out_o     (byte_out_o),
    .range_error_o  (range_error_o)
  );

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // apply one item to the buffer image and work out its result
  function automatic outcome_t buffer_op_outcome(op_e op, logic [7:0] addr, logic [7:0] data,
                                                 logic [VAL_W-1:0] src, logic [NB_W-1:0] nb);
    outcome_t         o;
    int               n;
    int               base;
    int               nbytes;
    int               pos;
    int               i;
    logic [VAL_W-1:0] bits;
    o.field_value = '0;
    o.byte_out    = '0;
    o.range_error = 1'b0;
    // lengths above the widest field and source counts above 8 saturate
    n      = (field_length > MAX_FIELD_BITS) ? MAX_FIELD_BITS : int'(field_length);
    base   = int'(field_index);
    nbytes = (nb > SRC_MAX) ? SRC_MAX : int'(nb);
    bits   = (nbytes == SRC_MAX) ? src : src & ((64'd1 << (8 * nbytes)) - 64'd1);
    case (op)
      OP_WR_BYTE: buf_image[addr] = data;
      OP_RD_BYTE: o.byte_out = buf_image[addr];
      default: begin
        // a field past the buffer end touches nothing
        if (base + n > BUF_BITS) begin
          o.range_error = 1'b1;
        end else if (op == OP_EXTRACT) begin
          for (i = 0; i < n; i++) begin
            pos = base + i;
            o.field_value[i] = buf_image[pos >> 3][pos & 7];
          end
        end else begin
          for (i = 0; i < n; i++) begin
            pos = base + i;
            buf_image[pos >> 3][pos & 7] = bits[i];
          end
        end
      end
    endcase
    return o;
  endfunction

  task automatic log_mismatch(string msg);
    // keep the log short on a badly broken block
    if (mismatches < PRINT_LIMIT) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  // present one item, with random idle cycles before it
  task automatic send_item(op_e op, logic [7:0] addr, logic [7:0] data,
                           logic [VAL_W-1:0] src, logic [NB_W-1:0] nb);
    while (!no_idling && $urandom_range(0, 99) < STALL_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    byte_addr_i    <= addr;
    byte_data_i    <= data;
    insert_value_i <= src;
    source_bytes_i <= nb;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    outcomes_due.push_back(buffer_op_outcome(op, addr, data, src, nb));
  endtask

  // stop sending and wait for every pending result
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_reg_e r, logic [CFG_DW-1:0] d);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i  <= d;
    @(posedge clk_i);
    if (r == REG_FIELD_INDEX) begin
      field_index = d[IDX_W-1:0];
    end else begin
      field_length = d[LEN_W-1:0];
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // new field setting, only once the block has gone idle
  task automatic set_field(logic [CFG_DW-1:0] index_data, logic [CFG_DW-1:0] length_data);
    drain_results();
    write_register(REG_FIELD_INDEX, index_data);
    write_register(REG_FIELD_LENGTH, length_data);
  endtask

  // byte writes and reads at both buffer ends, plus an untouched byte
  task automatic test_byte_access();
    send_item(OP_WR_BYTE, 8'h00, 8'hFF, '0, '0);
    send_item(OP_WR_BYTE, 8'hFF, 8'hA5, '0, '0);
    send_item(OP_RD_BYTE, 8'h00, 8'h00, '0, '0);
    send_item(OP_RD_BYTE, 8'hFF, 8'h00, '0, '0);
    send_item(OP_RD_BYTE, 8'h80, 8'hFF, '0, '0);
  endtask

  // field extremes: buffer ends, empty and oversized fields, source limits
  task automatic test_field_edges();
    // field left at its reset setting
    send_item(OP_EXTRACT, 8'h00, 8'h00, '0, '0);
    send_item(OP_INSERT, 8'h00, 8'h00, 64'h3C, 4'd1);
    send_item(OP_EXTRACT, 8'h00, 8'h00, '0, '0);
    // last bit of the buffer
    set_field(11'd2047, 11'd1);
    send_item(OP_INSERT, 8'h00, 8'h00, '0, 4'd8);
    send_item(OP_RD_BYTE, 8'hFF, 8'h00, '0, '0);
    send_item(OP_EXTRACT, 8'h00, 8'h00, '0, '0);
    // one bit past the end
    set_field(11'd2047, 11'd2);
    send_item(OP_EXTRACT, 8'h00, 8'h00, '0, '0);
    send_item(OP_INSERT, 8'h00, 8'h00, '1, 4'd8);
    // widest field ending exactly at the buffer end
    set_field(11'd1984, 11'd64);
    send_item(OP_INSERT, 8'h00, 8'h00, '1, 4'd8);
    send_item(OP_EXTRACT, 8'h00, 8'h00, '0, '0);
    send_item(OP_RD_BYTE, 8'hF8, 8'h00, '0, '0);
    // widest field one bit too far
    set_field(11'd1985, 11'd64);
    send_item(OP_EXTRACT, 8'h00, 8'h00, '0, '0);
    // empty field
    set_field(11'd5, 11'd0);
    send_item(OP_INSERT, 8'h00, 8'h00, '1, 4'd8);
    send_item(OP_EXTRACT, 8'h00, 8'h00, '0, '0);
    // length and source count both above their maximum
    set_field(11'd3, 11'd127);
    send_item(OP_INSERT, 8'h00, 8'h00, {$urandom, $urandom}, 4'd15);
    send_item(OP_EXTRACT, 8'h00, 8'h00, '0, '0);
    // length just above the maximum, no source bytes
    set_field(11'd60, 11'd65);
    send_item(OP_INSERT, 8'h00, 8'h00, '1, 4'd0);
    send_item(OP_EXTRACT, 8'h00, 8'h00, '0, '0);
    // two source bytes into a field that straddles three buffer bytes
    set_field(11'd12, 11'd20);
    send_item(OP_INSERT, 8'h00, 8'h00, '1, 4'd2);
    send_item(OP_EXTRACT, 8'h00, 8'h00, '0, '0);
    send_item(OP_RD_BYTE, 8'h01, 8'h00, '0, '0);
  endtask

  // phases of mixed items, each under its own field setting
  task automatic test_random_traffic();
    int                p;
    int                k;
    int                roll;
    logic [CFG_DW-1:0] idx_d;
    logic [CFG_DW-1:0] len_d;
    op_e               op;
    logic [7:0]        addr;
    logic [VAL_W-1:0]  src;
    logic [NB_W-1:0]   nb;
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin idx_d = 11'd0;    len_d = 11'd64;  end
        1: begin idx_d = 11'd2047; len_d = 11'd1;   end
        2: begin idx_d = 11'd1984; len_d = 11'd64;  end
        3: begin idx_d = 11'd1000; len_d = 11'd0;   end
        4: begin idx_d = 11'd7;    len_d = 11'd127; end
        default: begin
          idx_d = ($urandom_range(0, 9) < 7) ? CFG_DW'($urandom_range(0, 2047))
                                             : CFG_DW'($urandom_range(1900, 2047));
          // mostly legal lengths, some oversized, some with junk in the upper data bits
          roll = $urandom_range(0, 3);
          if (roll < 2) begin
            len_d = CFG_DW'($urandom_range(1, 64));
          end else if (roll == 2) begin
            len_d = CFG_DW'($urandom_range(0, 127));
          end else begin
            len_d = CFG_DW'($urandom);
          end
        end
      endcase
      set_field(idx_d, len_d);
      // one phase runs with both sides never idling
      no_idling = (p == 5);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        op = (roll < 25) ? OP_WR_BYTE : (roll < 40) ? OP_RD_BYTE :
             (roll < 70) ? OP_EXTRACT : OP_INSERT;
        // half of the byte accesses aim at or just past the bytes the field covers
        if ($urandom_range(0, 1) == 1) begin
          addr = 8'((field_index >> 3) + $urandom_range(0, 9));
        end else begin
          addr = 8'($urandom);
        end
        roll = $urandom_range(0, 9);
        src = (roll == 0) ? '1 : (roll == 1) ? '0 : {$urandom, $urandom};
        nb = ($urandom_range(0, 1) == 1) ? NB_W'(8) : NB_W'($urandom_range(0, 15));
        send_item(op, addr, 8'($urandom), src, nb);
      end
    end
    no_idling = 1'b0;
  endtask

  // receiver stalls
  always @(posedge clk_i) begin
    out_ready_i <= no_idling || ($urandom_range(0, 99) >= STALL_PCT);
  end

  // compare each result with the oldest pending one
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (outcomes_due.size() == 0) begin
        log_mismatch("result with no item pending");
      end else begin
        want = outcomes_due.pop_front();
        if (field_value_o !== want.field_value) begin
          log_mismatch($sformatf("field_value %h, expected %h", field_value_o,
                                 want.field_value));
        end
        if (byte_out_o !== want.byte_out) begin
          log_mismatch($sformatf("byte_out %h, expected %h", byte_out_o, want.byte_out));
        end
        if (range_error_o !== want.range_error) begin
          log_mismatch($sformatf("range_error %b, expected %b", range_error_o,
                                 want.range_error));
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_byte_access();
    test_field_edges();
    test_random_traffic();
    drain_results();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bfei_pkg.sv
rtl/bfei_ctrl.sv
rtl/bfei_datapath.sv
rtl/buffer_bit_field_extract_insert_top.sv
tb/tb_buffer_bit_field_extract_insert_top.sv
